FILE: sv/urb_pkg.sv
// Package for the UART receive/transmit ring-buffer pair.
// Request codes, internal operation codes and queue types.
// No dependencies.
`timescale 1ns / 1ps

package urb_pkg;

    localparam logic [2:0] REQ_RX_BYTE     = 3'd0;
    localparam logic [2:0] REQ_CPU_READ    = 3'd1;
    localparam logic [2:0] REQ_CPU_WRITE   = 3'd2;
    localparam logic [2:0] REQ_TX_EMPTY    = 3'd3;
    localparam logic [2:0] REQ_TX_COMPLETE = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_RX_PUSH = 3'd1,
        OP_RX_POP  = 3'd2,
        OP_TX_PUSH = 3'd3,
        OP_TX_SEND = 3'd4,
        OP_TX_DONE = 3'd5
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

endpackage

FILE: sv/urb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for both ring stores. No dependencies.
`timescale 1ns / 1ps

module urb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/urb_front.sv
// Front end: accepts request beats, decodes them into operations and
// holds them in a two-entry queue for the back end. Depends on urb_pkg.
`timescale 1ns / 1ps

module urb_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [2:0]     req_type,
    input  logic [7:0]     data_in,
    output urb_pkg::head_t head,
    input  logic           pop
);
    import urb_pkg::*;

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    op_t        op_dec;
    logic       push;

    always_comb
    begin
        unique case (req_type)
            REQ_RX_BYTE:     op_dec = OP_RX_PUSH;
            REQ_CPU_READ:    op_dec = OP_RX_POP;
            REQ_CPU_WRITE:   op_dec = OP_TX_PUSH;
            REQ_TX_EMPTY:    op_dec = OP_TX_SEND;
            REQ_TX_COMPLETE: op_dec = OP_TX_DONE;
            default:         op_dec = OP_NONE;
        endcase
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{op: op_dec, data: data_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = q_reg[rd_ptr_reg];

endmodule

FILE: sv/urb_back.sv
// Back end: ring pointers, interrupt enables, both ring stores and the
// result register. Depends on urb_pkg and urb_ram.
`timescale 1ns / 1ps

module urb_back #(
    parameter int RX_DEPTH = 256,
    parameter int TX_DEPTH = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  urb_pkg::head_t head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     data_out,
    output logic           data_valid,
    output logic           accepted,
    output logic           tx_empty_irq_on,
    output logic           tx_complete_irq_on,
    output logic           tx_done
);
    import urb_pkg::*;

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    typedef enum logic [1:0] {
        S_TAKE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [RX_AW-1:0] rx_wp_reg, rx_wp_next, rx_rp_reg, rx_rp_next;
    logic [TX_AW-1:0] tx_wp_reg, tx_wp_next, tx_rp_reg, tx_rp_next;
    logic             te_reg, te_next, tc_reg, tc_next;
    logic             sel_tx_reg, sel_tx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       data_out_reg, data_out_next;
    logic             data_valid_reg, data_valid_next;
    logic             accepted_reg, accepted_next;
    logic             te_out_reg, te_out_next;
    logic             tc_out_reg, tc_out_next;
    logic             done_reg, done_next;

    logic [RX_AW-1:0] rx_wp_inc, rx_rp_inc;
    logic [TX_AW-1:0] tx_wp_inc, tx_rp_inc;
    logic             rx_we, rx_re, tx_we, tx_re;
    logic [7:0]       rx_rdata, tx_rdata;
    logic             out_free;

    assign rx_wp_inc = (rx_wp_reg == RX_LAST) ? '0 : rx_wp_reg + 1'b1;
    assign rx_rp_inc = (rx_rp_reg == RX_LAST) ? '0 : rx_rp_reg + 1'b1;
    assign tx_wp_inc = (tx_wp_reg == TX_LAST) ? '0 : tx_wp_reg + 1'b1;
    assign tx_rp_inc = (tx_rp_reg == TX_LAST) ? '0 : tx_rp_reg + 1'b1;

    assign out_free = !out_valid_reg || !out_stall;

    urb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_wp_reg),
        .wdata (head.item.data),
        .re    (rx_re),
        .raddr (rx_rp_reg),
        .rdata (rx_rdata)
    );

    urb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_wp_reg),
        .wdata (head.item.data),
        .re    (tx_re),
        .raddr (tx_rp_reg),
        .rdata (tx_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        rx_wp_next      = rx_wp_reg;
        rx_rp_next      = rx_rp_reg;
        tx_wp_next      = tx_wp_reg;
        tx_rp_next      = tx_rp_reg;
        te_next         = te_reg;
        tc_next         = tc_reg;
        sel_tx_next     = sel_tx_reg;
        out_valid_next  = out_valid_reg;
        data_out_next   = data_out_reg;
        data_valid_next = data_valid_reg;
        accepted_next   = accepted_reg;
        te_out_next     = te_out_reg;
        tc_out_next     = tc_out_reg;
        done_next       = done_reg;
        pop             = 1'b0;
        rx_we           = 1'b0;
        rx_re           = 1'b0;
        tx_we           = 1'b0;
        tx_re           = 1'b0;

        unique case (state_reg)
            S_TAKE:
            begin
                if (head.valid && out_free)
                begin
                    pop             = 1'b1;
                    data_out_next   = 8'd0;
                    data_valid_next = 1'b0;
                    accepted_next   = 1'b0;
                    done_next       = 1'b0;
                    unique case (head.item.op)
                        OP_RX_PUSH:
                        begin
                            if (rx_wp_inc != rx_rp_reg)
                            begin
                                rx_we         = 1'b1;
                                rx_wp_next    = rx_wp_inc;
                                accepted_next = 1'b1;
                            end
                        end
                        OP_RX_POP:
                        begin
                            if (rx_wp_reg != rx_rp_reg)
                            begin
                                rx_re       = 1'b1;
                                rx_rp_next  = rx_rp_inc;
                                sel_tx_next = 1'b0;
                                state_next  = S_READ;
                            end
                        end
                        OP_TX_PUSH:
                        begin
                            if (tx_wp_inc != tx_rp_reg)
                            begin
                                tx_we         = 1'b1;
                                tx_wp_next    = tx_wp_inc;
                                accepted_next = 1'b1;
                                te_next       = 1'b1;
                                tc_next       = 1'b1;
                            end
                        end
                        OP_TX_SEND:
                        begin
                            if (te_reg)
                            begin
                                if (tx_wp_reg != tx_rp_reg)
                                begin
                                    tx_re       = 1'b1;
                                    tx_rp_next  = tx_rp_inc;
                                    sel_tx_next = 1'b1;
                                    state_next  = S_READ;
                                end
                                else
                                begin
                                    te_next = 1'b0;
                                end
                            end
                        end
                        OP_TX_DONE:
                        begin
                            if (tc_reg)
                            begin
                                done_next = 1'b1;
                                tc_next   = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    te_out_next    = te_next;
                    tc_out_next    = tc_next;
                    out_valid_next = (state_next != S_READ);
                end
                else if (out_valid_reg && !out_stall)
                begin
                    out_valid_next = 1'b0;
                end
            end
            S_READ:
            begin
                data_out_next   = sel_tx_reg ? tx_rdata : rx_rdata;
                data_valid_next = 1'b1;
                out_valid_next  = 1'b1;
                state_next      = S_TAKE;
            end
            default:
            begin
                state_next = S_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sel_tx_reg     <= sel_tx_next;
        data_out_reg   <= data_out_next;
        data_valid_reg <= data_valid_next;
        accepted_reg   <= accepted_next;
        te_out_reg     <= te_out_next;
        tc_out_reg     <= tc_out_next;
        done_reg       <= done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_TAKE;
            rx_wp_reg     <= '0;
            rx_rp_reg     <= '0;
            tx_wp_reg     <= '0;
            tx_rp_reg     <= '0;
            te_reg        <= 1'b0;
            tc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rx_wp_reg     <= rx_wp_next;
            rx_rp_reg     <= rx_rp_next;
            tx_wp_reg     <= tx_wp_next;
            tx_rp_reg     <= tx_rp_next;
            te_reg        <= te_next;
            tc_reg        <= tc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign data_out           = data_out_reg;
    assign data_valid         = data_valid_reg;
    assign accepted           = accepted_reg;
    assign tx_empty_irq_on    = te_out_reg;
    assign tx_complete_irq_on = tc_out_reg;
    assign tx_done            = done_reg;

endmodule

FILE: sv/uart_rx_tx_ring_buffers_top.sv
// Top level of the UART receive/transmit ring-buffer pair.
// Instantiates urb_front and urb_back; depends on urb_pkg.
//
// Channel  Signals                                     Beat
// -------  ------------------------------------------  ---------------------------
// in       in_valid, in_stall, req_type, data_in       one request
// out      out_valid, out_stall, data_out, data_valid,  one result per request
//          accepted, tx_empty_irq_on,
//          tx_complete_irq_on, tx_done
//
// A request waits in a two-entry queue and is then handled in S_TAKE; one that
// pops a byte also passes through S_READ, as the ring stores have a registered
// read port. Its result is registered in the cycle after the request is taken,
// or for a pop after S_READ has captured the read data.
// Reset clears pointers and enables; store contents are not cleared.
// out_stall holds the result register; the queue then fills and raises in_stall.
`timescale 1ns / 1ps

module uart_rx_tx_ring_buffers_top #(
    parameter int RX_DEPTH = 256,
    parameter int TX_DEPTH = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] req_type,
    input  logic [7:0] data_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] data_out,
    output logic       data_valid,
    output logic       accepted,
    output logic       tx_empty_irq_on,
    output logic       tx_complete_irq_on,
    output logic       tx_done
);
    import urb_pkg::*;

    head_t head;
    logic  pop;

    urb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .data_in  (data_in),
        .head     (head),
        .pop      (pop)
    );

    urb_back #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .head               (head),
        .pop                (pop),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .data_out           (data_out),
        .data_valid         (data_valid),
        .accepted           (accepted),
        .tx_empty_irq_on    (tx_empty_irq_on),
        .tx_complete_irq_on (tx_complete_irq_on),
        .tx_done            (tx_done)
    );

    a_done_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tx_done |-> !data_valid && !accepted && !tx_complete_irq_on)
        else $error("tx_done beat carries other activity");

    a_pop_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_valid |-> !accepted)
        else $error("beat both popped and stored a byte");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable({data_out, data_valid, accepted,
            tx_empty_irq_on, tx_complete_irq_on, tx_done}))
        else $error("stalled result beat changed");

    a_idle_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !data_valid |-> data_out == 8'd0)
        else $error("data_out nonzero without a popped byte");

endmodule
